@@ design/skvt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sorted key/value upsert table
// no dependencies
package skvt_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_UPDATED  = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_UNUSED   = 2'd3;

  typedef struct packed {
    logic signed [31:0] new_key;
    logic signed [31:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [6:0] entry_total;
  } out_beat_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic apply_en;
    logic do_insert;
    logic do_update;
  } cell_ctrl_t;

endpackage

@@ design/skvt_cell.sv @@
`timescale 1ns / 1ps
// one slot of the sorted table: holds a key/value pair and its compare flags
// depends on skvt_pkg
module skvt_cell
  import skvt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic               occupied,
  input  logic signed [31:0] bcast_key,
  input  logic signed [31:0] bcast_value,
  input  logic               prev_lt,
  input  logic signed [31:0] prev_key,
  input  logic signed [31:0] prev_value,
  output logic               lt_r,
  output logic               eq_r,
  output logic signed [31:0] key_r,
  output logic signed [31:0] value_r
);

  logic at_pos;

  // first slot not below the new key
  assign at_pos = !lt_r && prev_lt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      lt_r <= occupied && (key_r < bcast_key);
      eq_r <= occupied && (key_r == bcast_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply_en) begin
      if (ctrl.do_update && eq_r) begin
        value_r <= bcast_value;
      end else if (ctrl.do_insert && !lt_r) begin
        if (at_pos) begin
          key_r   <= bcast_key;
          value_r <= bcast_value;
        end else begin
          // shift up from the lower neighbour
          key_r   <= prev_key;
          value_r <= prev_value;
        end
      end
    end
  end

endmodule

@@ design/sorted_key_value_upsert_table_core.sv @@
`timescale 1ns / 1ps
// an input beat is captured, compared in every cell of the row, then applied (capture, compare, apply)
// one item at a time: no new beat is taken until the apply pass of the last one is done
// the input side is free again as soon as the result is registered
// reset: synchronous active-low rst_n empties the table (count to zero); slot contents
// are left as they are and are never read above the count
module sorted_key_value_upsert_table_core
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  in_beat_t         item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_beat_t        out_r;
  logic             out_valid_r, out_valid_nxt;

  // per-cell flags and data
  logic [CAPACITY-1:0]       lt_v, eq_v, bound_v;
  logic signed [31:0]        key_v   [CAPACITY];
  logic signed [31:0]        value_v [CAPACITY];

  cell_ctrl_t       ctrl;
  logic             apply_go;
  logic             found, full;
  logic [CNT_W-1:0] pos;
  logic [CNT_W+6:0] pos_ext, cnt_ext;
  logic [1:0]       status;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // apply waits while an earlier result is still pending
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // key already held: only the matching cell raises eq
  assign found = |eq_v;
  assign full  = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.cmp_en    = (state_r == S_CMP);
    ctrl.apply_en  = apply_go;
    ctrl.do_update = found;
    ctrl.do_insert = !found && !full;
  end

  // lt flags form a thermometer over the sorted row; the edge gives the position
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound_v[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
    if (lt_v[CAPACITY-1]) begin
      pos = CNT_W'(CAPACITY);
    end
  end

  always_comb begin
    if (found) begin
      status    = ST_UPDATED;
      count_nxt = count_r;
    end else if (full) begin
      status    = ST_DROPPED;
      count_nxt = count_r;
    end else begin
      status    = ST_INSERTED;
      count_nxt = count_r + CNT_W'(1);
    end
    pos_ext = {7'd0, pos};
    cnt_ext = {7'd0, count_nxt};
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic               p_lt;
    logic signed [31:0] p_key, p_val;

    if (g == 0) begin : g_head
      assign p_lt  = 1'b1;
      assign p_key = item_r.new_key;
      assign p_val = item_r.new_value;
    end else begin : g_body
      assign p_lt  = lt_v[g-1];
      assign p_key = key_v[g-1];
      assign p_val = value_v[g-1];
    end

    assign bound_v[g] = !lt_v[g] && p_lt;

    skvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .occupied   (count_r > CNT_W'(g)),
      .bcast_key  (item_r.new_key),
      .bcast_value(item_r.new_value),
      .prev_lt    (p_lt),
      .prev_key   (p_key),
      .prev_value (p_val),
      .lt_r       (lt_v[g]),
      .eq_r       (eq_v[g]),
      .key_r      (key_v[g]),
      .value_r    (value_v[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply_go) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_beat;
    end
    if (apply_go) begin
      out_r.status      <= status;
      out_r.position    <= pos_ext[6:0];
      out_r.entry_total <= cnt_ext[6:0];
    end
  end

endmodule

@@ design/skvt_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the sorted key/value upsert table
// depends on skvt_pkg; bound to sorted_key_value_upsert_table_core
module skvt_checker
  import skvt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_beat
);

  // an offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_beat))
    else $error("input beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // status code three is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.status != ST_UNUSED)
    else $error("illegal status code");

  // one item in flight: input closes right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a fresh result only follows the compare pass, never the accept edge
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without a compare pass");

endmodule

bind sorted_key_value_upsert_table_core skvt_checker u_skvt_checker (.*);
